// ===== rtl/vcdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// vcdtc_pkg
// Shared types, codes and keyword tables of the dump token classifier.
// ----------------------------------------------------------------------------
package vcdtc_pkg;

    localparam int LENGTH_LIMIT = 255;
    localparam int TIME_BITS    = 48;
    localparam int NUM_KW       = 13;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [4:0] KIND_IDENT  = 5'd0;
    localparam logic [4:0] KIND_TIME   = 5'd14;
    localparam logic [4:0] KIND_SCALAR = 5'd15;
    localparam logic [4:0] KIND_VECTOR = 5'd16;
    localparam logic [4:0] KIND_ERROR  = 5'd17;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_VEC_NOID = 2'd2;
    localparam logic [1:0] ERR_DATA_TOK = 2'd3;

    localparam logic [1:0] PHASE_DEFS  = 2'd0;
    localparam logic [1:0] PHASE_DUMP  = 2'd1;
    localparam logic [1:0] PHASE_AFTER = 2'd2;

    localparam int KW_END     = 1;
    localparam int KW_COMMENT = 4;
    localparam int KW_ENDDEFS = 8;

    localparam logic [127:0] KW_TEXT [NUM_KW] = '{
        "$date", "$end", "$version", "$timescale", "$comment", "$scope",
        "$upscope", "$var", "$enddefinitions", "$dumpvars", "$dumpall",
        "$dumpon", "$dumpoff"
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd4, 4'd8, 4'd10, 4'd8, 4'd6, 4'd8, 4'd4, 4'd15, 4'd9, 4'd8,
        4'd7, 4'd8
    };

    typedef struct packed {
        logic [4:0]           token_kind;
        logic [7:0]           token_length;
        logic [TIME_BITS-1:0] time_value;
        logic [1:0]           error_code;
        logic                 last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [3:0] idx;
        idx = KW_LEN[k] - 4'd1 - pos;
        return KW_TEXT[k][{idx, 3'b000} +: 8];
    endfunction

    function automatic logic is_scalar_mark(input logic [7:0] c);
        return (c == "0") || (c == "1") || (c == "x") || (c == "X") ||
               (c == "z") || (c == "Z");
    endfunction

endpackage

// ===== rtl/vcdtc_if.sv =====
// ----------------------------------------------------------------------------
// vcdtc_if
// Request and result channels of the dump token classifier.
// ----------------------------------------------------------------------------
interface vcdtc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, output char_byte, output end_of_text, input ready);
    modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface vcdtc_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [7:0]  token_length;
    logic [47:0] time_value;
    logic [1:0]  error_code;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_length,
                    output time_value, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_length,
                    input time_value, input error_code, input last_of_run,
                    output ready);
endinterface

// ===== rtl/vcdtc_core.sv =====
// ----------------------------------------------------------------------------
// vcdtc_core
// Per-byte tokenizer state and token classification; emits up to two results.
// ----------------------------------------------------------------------------
module vcdtc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_char,
    input  logic              i_eot,
    output vcdtc_pkg::t_push  o_push
);
    import vcdtc_pkg::*;

    logic [1:0]           r_phase, n_phase;
    logic                 r_comment, n_comment;
    logic                 r_halted, n_halted;
    logic [7:0]           r_len, n_len;
    logic [7:0]           r_first, n_first;
    logic [NUM_KW-1:0]    r_cand, n_cand;
    logic                 r_digits, n_digits;
    logic                 r_vbits, n_vbits;
    logic [TIME_BITS-1:0] r_acc, n_acc;

    logic                 is_ws, is_prt, is_bad;
    logic [7:0]           t_len, t_first;
    logic [NUM_KW-1:0]    t_cand;
    logic                 t_digits, t_vbits;
    logic [TIME_BITS-1:0] t_acc;
    logic [TIME_BITS+3:0] acc_x10;
    logic                 flush, found, bad_emit;
    logic [4:0]           fl_kind;
    logic [1:0]           fl_err;
    logic [TIME_BITS-1:0] fl_time;
    logic [1:0]           fl_phase;
    logic                 fl_comment;
    t_result              fl_res, bad_res;

    always_comb begin
        is_ws  = (i_char == 8'h20) || (i_char == 8'h09) || (i_char == 8'h0A) ||
                 (i_char == 8'h0D);
        is_prt = (i_char >= 8'h21) && (i_char <= 8'h7E);
        is_bad = !is_ws && !is_prt;

        // absorb
        t_len    = r_len;
        t_first  = r_first;
        t_cand   = r_cand;
        t_digits = r_digits;
        t_vbits  = r_vbits;
        t_acc    = r_acc;
        acc_x10  = {1'b0, r_acc, 3'b000} + {3'b0, r_acc, 1'b0} +
                   {(TIME_BITS)'(0), i_char[3:0]};
        if (is_prt) begin
            if (r_len == 8'd0) begin
                t_first = i_char;
            end else begin
                t_digits = r_digits && (i_char >= "0") && (i_char <= "9");
                t_vbits  = r_vbits && is_scalar_mark(i_char);
                if (t_digits) begin
                    t_acc = (acc_x10 > {4'b0, TIME_MAX}) ? TIME_MAX
                                                         : acc_x10[TIME_BITS-1:0];
                end
            end
            for (int k = 0; k < NUM_KW; k++) begin
                if (!((r_len < {4'b0, KW_LEN[k]}) && (kw_char(k, r_len[3:0]) == i_char))) begin
                    t_cand[k] = 1'b0;
                end
            end
            if (r_len < 8'(LENGTH_LIMIT)) begin
                t_len = r_len + 8'd1;
            end
        end

        flush = !r_halted && ((((is_ws || is_bad) && (r_len != 8'd0))) ||
                              (is_prt && i_eot));

        // classify
        found      = 1'b0;
        fl_kind    = KIND_IDENT;
        fl_err     = ERR_NONE;
        fl_time    = '0;
        fl_phase   = r_phase;
        fl_comment = r_comment;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!found && t_cand[k] && (t_len == {4'b0, KW_LEN[k]})) begin
                found   = 1'b1;
                fl_kind = 5'(k + 1);
                if (k == KW_END)     fl_comment = 1'b0;
                if (k == KW_COMMENT) fl_comment = 1'b1;
                if (k == KW_ENDDEFS) fl_phase   = PHASE_DUMP;
            end
        end
        if (!found) begin
            if ((t_first == "#") && t_digits) begin
                if (r_phase == PHASE_AFTER) begin
                    fl_err = ERR_VEC_NOID;
                end else if (r_phase == PHASE_DUMP) begin
                    fl_kind = KIND_TIME;
                    fl_time = t_acc;
                end
            end else if (r_phase == PHASE_DUMP) begin
                if (is_scalar_mark(t_first)) begin
                    fl_kind = KIND_SCALAR;
                end else if (((t_first == "b") || (t_first == "B")) && t_vbits) begin
                    fl_kind  = KIND_VECTOR;
                    fl_phase = PHASE_AFTER;
                end else if (!r_comment) begin
                    fl_err = ERR_DATA_TOK;
                end
            end else if (r_phase == PHASE_AFTER) begin
                fl_phase = PHASE_DUMP;
            end
        end

        fl_res.token_kind   = (fl_err != ERR_NONE) ? KIND_ERROR : fl_kind;
        fl_res.token_length = t_len;
        fl_res.time_value   = (fl_err != ERR_NONE) ? '0 : fl_time;
        fl_res.error_code   = fl_err;
        fl_res.last_of_run  = 1'b0;

        bad_res.token_kind   = KIND_ERROR;
        bad_res.token_length = 8'd0;
        bad_res.time_value   = '0;
        bad_res.error_code   = ERR_BAD_CHAR;
        bad_res.last_of_run  = 1'b1;

        bad_emit = !r_halted && is_bad && !(flush && (fl_err != ERR_NONE));

        o_push.count = '0;
        o_push.res0  = bad_res;
        o_push.res1  = bad_res;
        if (i_accept) begin
            if (flush) begin
                o_push.res0             = fl_res;
                o_push.res0.last_of_run = !bad_emit;
                o_push.count            = bad_emit ? 2'd2 : 2'd1;
            end else if (bad_emit) begin
                o_push.count = 2'd1;
            end
        end

        // next state
        n_phase   = r_phase;
        n_comment = r_comment;
        n_halted  = r_halted;
        n_len     = r_len;
        n_first   = r_first;
        n_cand    = r_cand;
        n_digits  = r_digits;
        n_vbits   = r_vbits;
        n_acc     = r_acc;
        if (i_accept && !r_halted) begin
            if (flush) begin
                n_phase   = fl_phase;
                n_comment = fl_comment;
                n_halted  = (fl_err != ERR_NONE) || is_bad;
                n_len     = 8'd0;
                n_first   = 8'd0;
                n_cand    = '1;
                n_digits  = 1'b1;
                n_vbits   = 1'b1;
                n_acc     = '0;
            end else if (is_bad) begin
                n_halted = 1'b1;
            end else if (is_prt) begin
                n_len    = t_len;
                n_first  = t_first;
                n_cand   = t_cand;
                n_digits = t_digits;
                n_vbits  = t_vbits;
                n_acc    = t_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_DEFS;
            r_comment <= 1'b0;
            r_halted  <= 1'b0;
            r_len     <= 8'd0;
            r_first   <= 8'd0;
            r_cand    <= '1;
            r_digits  <= 1'b1;
            r_vbits   <= 1'b1;
            r_acc     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_comment <= n_comment;
            r_halted  <= n_halted;
            r_len     <= n_len;
            r_first   <= n_first;
            r_cand    <= n_cand;
            r_digits  <= n_digits;
            r_vbits   <= n_vbits;
            r_acc     <= n_acc;
        end
    end

endmodule

// ===== rtl/vcdtc_outq.sv =====
// ----------------------------------------------------------------------------
// vcdtc_outq
// Small result queue; takes up to two results a cycle, delivers one.
// ----------------------------------------------------------------------------
module vcdtc_outq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vcdtc_pkg::t_push        i_push,
    input  logic                    i_pop,
    output logic                    o_space,
    output logic                    o_valid,
    output vcdtc_pkg::t_result      o_head
);
    import vcdtc_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_head  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.count);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(i_push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/vcd_token_classifier.sv =====
// ----------------------------------------------------------------------------
// vcd_token_classifier
// Value change dump tokenizer: classifies whitespace-separated tokens.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the queue has room for two results;
// a request yields zero, one or two results, which are registered into a
// four-entry result queue and drained one per cycle while the sink is ready.
// Reset: synchronous, active low; clears tokenizer state and empties the queue.
module vcd_token_classifier (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vcdtc_req_if.sink       i_req,
    vcdtc_res_if.source     o_res
);
    import vcdtc_pkg::*;

    t_push   push;
    t_result head;
    logic    space;
    logic    accept;

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;

    vcdtc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_req.char_byte),
        .i_eot    (i_req.end_of_text),
        .o_push   (push)
    );

    vcdtc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_space (space),
        .o_valid (o_res.valid),
        .o_head  (head)
    );

    assign o_res.token_kind   = head.token_kind;
    assign o_res.token_length = head.token_length;
    assign o_res.time_value   = head.time_value;
    assign o_res.error_code   = head.error_code;
    assign o_res.last_of_run  = head.last_of_run;

endmodule
